@@ sv/rmsd_pkg.sv @@
package rmsd_pkg;

   localparam int FRAME_W = 20;
   localparam int INDEX_W = 32;
   localparam int EVENT_W = 7;

   // csr register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_SPIKE_ENABLE = 3'd0;
   localparam logic [2:0] REG_FRAME_BUDGET = 3'd1;
   localparam logic [2:0] REG_DELTA_THRESH = 3'd2;
   localparam logic [2:0] REG_WINDOW       = 3'd3;
   localparam logic [2:0] REG_PRE          = 3'd4;
   localparam logic [2:0] REG_POST         = 3'd5;
   localparam logic [2:0] REG_MAX_EVENTS   = 3'd6;

   // request function codes
   localparam logic FUNC_SAMPLE  = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   localparam logic [19:0] BUDGET_RST = 20'd16667;
   localparam logic [19:0] BUDGET_MIN = 20'd100;
   localparam logic [19:0] BUDGET_MAX = 20'd1000000;
   localparam logic [19:0] DELTA_RST  = 20'd5000;
   localparam logic [19:0] DELTA_MIN  = 20'd10;
   localparam logic [19:0] DELTA_MAX  = 20'd1000000;
   localparam logic [19:0] WINDOW_RST = 20'd120;
   localparam logic [19:0] WINDOW_MIN = 20'd30;
   localparam logic [19:0] WINDOW_MAX = 20'd600;
   localparam logic [19:0] PRE_RST    = 20'd30;
   localparam logic [19:0] PRE_MAX    = 20'd300;
   localparam logic [19:0] POST_RST   = 20'd30;
   localparam logic [19:0] POST_MAX   = 20'd600;
   localparam logic [19:0] MAXEV_RST  = 20'd10;
   localparam logic [19:0] MAXEV_MIN  = 20'd1;
   localparam logic [19:0] MAXEV_MAX  = 20'd100;

   typedef struct packed {
      logic               func;
      logic [FRAME_W-1:0] frame_us;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] frame_index;
      logic [FRAME_W-1:0] median_us;
      logic               baseline_ready;
      logic               is_spike;
      logic               event_started;
      logic               event_ended;
      logic               event_active;
      logic [EVENT_W-1:0] event_number;
      logic               peak_updated;
      logic [INDEX_W-1:0] window_start;
   } rsp_type;

   // command broadcast to every cell of the sorted chain
   typedef struct packed {
      logic               ins;
      logic               evict;
      logic [FRAME_W-1:0] key;
   } cell_cmd_type;

   function automatic logic [19:0] clamp20(input logic [19:0] v, input logic [19:0] lo,
                                           input logic [19:0] hi);
      logic [19:0] r;
      r = v;
      if (v < lo) r = lo;
      if (v > hi) r = hi;
      return r;
   endfunction

endpackage

@@ sv/rmsd_cell.sv @@
module rmsd_cell import rmsd_pkg::*; #(
   parameter int CountWidth = 11,
   parameter int Idx        = 0
) (
   input  logic                  clock,
   input  cell_cmd_type          cmd,
   input  logic [CountWidth-1:0] count,
   input  logic [FRAME_W-1:0]    left_val,
   input  logic                  left_gt,
   input  logic [FRAME_W-1:0]    right_val,
   input  logic                  right_valid,
   output logic [FRAME_W-1:0]    val,
   output logic                  gt,
   output logic                  valid
);

   logic [FRAME_W-1:0] val_ff, val_in;

   assign valid = count > CountWidth'(Idx);
   // empty cells count as greater, so a new key lands at the first one
   assign gt    = !valid || (val_ff > cmd.key);
   assign val   = val_ff;

   always_comb begin
      val_in = val_ff;
      if (cmd.ins) begin
         if (gt) val_in = left_gt ? left_val : cmd.key;
      end else if (cmd.evict) begin
         // drop the last copy of key: everything right of it moves left
         if (!right_valid || (right_val > cmd.key)) val_in = right_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

@@ sv/rmsd_chain.sv @@
module rmsd_chain import rmsd_pkg::*; #(
   parameter int Depth      = 1024,
   parameter int CountWidth = 11
) (
   input  logic                  clock,
   input  cell_cmd_type          cmd,
   input  logic [CountWidth-1:0] count,
   output logic [FRAME_W-1:0]    lo,
   output logic [FRAME_W-1:0]    hi
);

   logic [FRAME_W-1:0] vals [Depth];
   logic               gts  [Depth];
   logic               vlds [Depth];

   for (genvar k = 0; k < Depth; k++) begin : g_cell
      logic [FRAME_W-1:0] lv, rv;
      logic               lg, rvld;
      if (k == 0) begin : g_first
         assign lv = '0;
         assign lg = 1'b0;
      end else begin : g_mid
         assign lv = vals[k-1];
         assign lg = gts[k-1];
      end
      if (k == Depth - 1) begin : g_last
         assign rv   = '0;
         assign rvld = 1'b0;
      end else begin : g_notlast
         assign rv   = vals[k+1];
         assign rvld = vlds[k+1];
      end
      rmsd_cell #(.CountWidth(CountWidth), .Idx(k)) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count),
         .left_val    (lv),
         .left_gt     (lg),
         .right_val   (rv),
         .right_valid (rvld),
         .val         (vals[k]),
         .gt          (gts[k]),
         .valid       (vlds[k])
      );
   end

   // middle taps; count even: mid-1 and mid, odd: mid twice
   logic [CountWidth-1:0] mid;
   logic [FRAME_W-1:0]    at_mid, below_mid;

   assign mid = count >> 1;

   always_comb begin
      at_mid    = '0;
      below_mid = '0;
      for (int k = 0; k < Depth; k++) begin
         if (mid == CountWidth'(k)) at_mid = vals[k];
         if (mid == CountWidth'(k + 1)) below_mid = vals[k];
      end
   end

   assign hi = at_mid;
   assign lo = count[0] ? at_mid : below_mid;

endmodule

@@ sv/rolling_median_spike_detector.sv @@
// Rolling median frame-time spike detector.
// req channel: one word per item, valid/ready. func = sample or restart,
//   frame_us = frame time in microseconds.
// rsp channel: one word per accepted sample (restart gives none), carrying
//   index, median before the sample, spike flag and event bookkeeping.
// csr port: APB-style, pready tied high, registers at 4*index, writes are
//   clamped to each register's range. Write only while the block is idle.
// Sequence: a sample that needs no eviction goes from accept through median
//   read, insert and output load to rsp_valid. Once the history reaches its
//   limit each sample first evicts one entry. Each further eviction after
//   lowering the history limit adds a ring read and an evict. With detection
//   disabled a sample goes straight to the output load. A new item is taken
//   only once the block is idle again; the sorted cell chain takes one
//   insert or one evict per cycle, and the ring memory's registered read
//   paces evictions. A restart word is taken in the accept cycle.
// Reset: synchronous, clears history count, counters and event state and
//   sets registers to their defaults; cell and ring contents are not cleared,
//   only the first history-count entries are ever read.
// Stall: the result waits in an output register while the block takes the next
//   item; a further result then waits until it is taken, and req_ready stays low meanwhile.
module rolling_median_spike_detector import rmsd_pkg::*; #(
   parameter int HISTORY_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_word,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CountWidth = $clog2(HISTORY_DEPTH + 1);
   localparam int HeadWidth  = $clog2(HISTORY_DEPTH);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MED   = 3'd1;
   localparam logic [2:0] ST_RD    = 3'd2;
   localparam logic [2:0] ST_EVICT = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   // ---------------- configuration registers ----------------
   logic        enable_ff;
   logic [19:0] budget_ff, delta_ff;
   logic [9:0]  window_ff, post_ff;
   logic [8:0]  pre_ff;
   logic [6:0]  maxev_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         budget_ff <= BUDGET_RST;
         delta_ff  <= DELTA_RST;
         window_ff <= WINDOW_RST[9:0];
         pre_ff    <= PRE_RST[8:0];
         post_ff   <= POST_RST[9:0];
         maxev_ff  <= MAXEV_RST[6:0];
      end else if (wr_en) begin
         unique case (paddr[4:2])
            REG_SPIKE_ENABLE: enable_ff <= pwdata[0];
            REG_FRAME_BUDGET: budget_ff <= clamp20(pwdata[19:0], BUDGET_MIN, BUDGET_MAX);
            REG_DELTA_THRESH: delta_ff  <= clamp20(pwdata[19:0], DELTA_MIN, DELTA_MAX);
            REG_WINDOW: window_ff <= 10'(clamp20({10'd0, pwdata[9:0]}, WINDOW_MIN, WINDOW_MAX));
            REG_PRE:    pre_ff    <= 9'(clamp20({11'd0, pwdata[8:0]}, 20'd0, PRE_MAX));
            REG_POST:   post_ff   <= 10'(clamp20({10'd0, pwdata[9:0]}, 20'd0, POST_MAX));
            REG_MAX_EVENTS: maxev_ff <= 7'(clamp20({13'd0, pwdata[6:0]}, MAXEV_MIN, MAXEV_MAX));
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_SPIKE_ENABLE: prdata = {31'd0, enable_ff};
         REG_FRAME_BUDGET: prdata = {12'd0, budget_ff};
         REG_DELTA_THRESH: prdata = {12'd0, delta_ff};
         REG_WINDOW:       prdata = {22'd0, window_ff};
         REG_PRE:          prdata = {23'd0, pre_ff};
         REG_POST:         prdata = {22'd0, post_ff};
         REG_MAX_EVENTS:   prdata = {25'd0, maxev_ff};
         default:          prdata = '0;
      endcase
   end

   // ---------------- capture state ----------------
   logic [2:0]            state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [HeadWidth-1:0]  head_ff, head_in;
   logic [31:0]           sample_ff, sample_in;
   logic                  open_ff, open_in;
   logic [6:0]            events_ff, events_in;
   logic [31:0]           last_ff, last_in;
   logic [19:0]           peak_ff, peak_in;
   logic [19:0]           frame_ff, frame_in;
   logic [31:0]           idx_ff, idx_in;
   rsp_type               pend_ff, pend_in;
   rsp_type               out_ff, out_in;
   logic                  out_vld_ff, out_vld_in;

   // ring of samples in arrival order, oldest at head
   logic [19:0]           ring [HISTORY_DEPTH];
   logic [19:0]           old_ff;
   logic                  ring_we;
   logic [HeadWidth-1:0]  tail;
   logic [CountWidth:0]   tail_sum;

   assign tail_sum = (CountWidth+1)'(head_ff) + (CountWidth+1)'(count_ff);
   assign tail = (tail_sum >= (CountWidth+1)'(HISTORY_DEPTH))
               ? HeadWidth'(tail_sum - (CountWidth+1)'(HISTORY_DEPTH))
               : HeadWidth'(tail_sum);

   always_ff @(posedge clock) begin
      if (ring_we) ring[tail] <= frame_ff;
      old_ff <= ring[head_ff];
   end

   // sorted chain
   cell_cmd_type    cmd;
   logic [19:0]     lo, hi;

   rmsd_chain #(.Depth(HISTORY_DEPTH), .CountWidth(CountWidth)) u_chain (
      .clock (clock),
      .cmd   (cmd),
      .count (count_ff),
      .lo    (lo),
      .hi    (hi)
   );

   // evaluation terms
   logic [20:0]           mid_sum;
   logic [21:0]           spike_rhs;
   logic                  ready_c, spike_c;
   logic [CountWidth-1:0] limit;
   logic                  need_evict;
   logic                  accept;
   logic                  out_free;

   assign mid_sum   = {1'b0, lo} + {1'b0, hi};
   assign spike_rhs = {1'b0, mid_sum} + {1'b0, delta_ff, 1'b0};
   assign ready_c   = (count_ff >= CountWidth'(window_ff)) && (count_ff != '0);
   assign spike_c   = ready_c && (frame_ff >= budget_ff) && ({1'b0, frame_ff, 1'b0} >= spike_rhs);
   assign limit     = (window_ff > {1'b0, pre_ff}) ? CountWidth'(window_ff) : CountWidth'(pre_ff);
   assign need_evict = (count_ff != '0) &&
                       ((count_ff >= limit) || (count_ff >= CountWidth'(HISTORY_DEPTH)));

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_vld_ff || rsp_ready;
   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      head_in    = head_ff;
      sample_in  = sample_ff;
      open_in    = open_ff;
      events_in  = events_ff;
      last_in    = last_ff;
      peak_in    = peak_ff;
      frame_in   = frame_ff;
      idx_in     = idx_ff;
      pend_in    = pend_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_ready;
      ring_we    = 1'b0;
      cmd        = '{ins: 1'b0, evict: 1'b0, key: frame_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.func == FUNC_RESTART) begin
                  count_in  = '0;
                  sample_in = '0;
                  open_in   = 1'b0;
                  events_in = '0;
                  last_in   = '0;
                  peak_in   = '0;
               end else begin
                  frame_in = req_word.frame_us;
                  idx_in   = sample_ff;
                  if (sample_ff != 32'hFFFF_FFFF) sample_in = sample_ff + 32'd1;
                  if (enable_ff) begin
                     state_in = ST_MED;
                  end else begin
                     // disabled: only the index and event count are reported
                     pend_in              = '0;
                     pend_in.frame_index  = sample_ff;
                     pend_in.event_number = events_ff;
                     state_in             = ST_DONE;
                  end
               end
            end
         end
         ST_MED: begin
            pend_in                = '0;
            pend_in.frame_index    = idx_ff;
            pend_in.baseline_ready = ready_c;
            pend_in.median_us      = ready_c ? mid_sum[20:1] : '0;
            pend_in.is_spike       = spike_c;
            if (open_ff) begin
               if (spike_c) begin
                  last_in = idx_ff;
                  if (frame_ff > peak_ff) begin
                     peak_in              = frame_ff;
                     pend_in.peak_updated = 1'b1;
                  end
               end else if ((idx_ff - last_ff) >= {22'd0, post_ff}) begin
                  open_in             = 1'b0;
                  pend_in.event_ended = 1'b1;
               end
            end else if (spike_c && (events_ff < maxev_ff)) begin
               events_in             = events_ff + 7'd1;
               open_in               = 1'b1;
               last_in               = idx_ff;
               peak_in               = frame_ff;
               pend_in.event_started = 1'b1;
               pend_in.peak_updated  = 1'b1;
               pend_in.window_start  = (idx_ff >= {23'd0, pre_ff})
                                     ? idx_ff - {23'd0, pre_ff} : '0;
            end
            pend_in.event_active = open_in;
            pend_in.event_number = events_in;
            state_in = ST_EVICT;
         end
         ST_RD: begin
            // old_ff catches up with the new head
            state_in = ST_EVICT;
         end
         ST_EVICT: begin
            if (need_evict) begin
               cmd.evict = 1'b1;
               cmd.key   = old_ff;
               count_in  = count_ff - CountWidth'(1);
               head_in   = (head_ff == HeadWidth'(HISTORY_DEPTH - 1))
                         ? '0 : head_ff + HeadWidth'(1);
               state_in  = ST_RD;
            end else begin
               cmd.ins  = 1'b1;
               ring_we  = 1'b1;
               count_in = count_ff + CountWidth'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_in     = pend_ff;
               out_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         head_ff    <= '0;
         sample_ff  <= '0;
         open_ff    <= 1'b0;
         events_ff  <= '0;
         last_ff    <= '0;
         peak_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         head_ff    <= head_in;
         sample_ff  <= sample_in;
         open_ff    <= open_in;
         events_ff  <= events_in;
         last_ff    <= last_in;
         peak_ff    <= peak_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      idx_ff   <= idx_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

endmodule

@@ sv/rmsd_checker.sv @@
module rmsd_checker import rmsd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_word
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed");

   a_start_spike: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.event_started |-> rsp_word.is_spike && rsp_word.event_active)
      else $error("event opened without spike");

   a_peak_spike: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.peak_updated |-> rsp_word.is_spike && rsp_word.event_active)
      else $error("peak update without spike");

   a_spike_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.is_spike |-> rsp_word.baseline_ready && !rsp_word.event_ended)
      else $error("spike without baseline");

endmodule

bind rolling_median_spike_detector rmsd_checker u_rmsd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

@@ bench/tb_top.sv @@
module tb_top;
   import rmsd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 1024;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 40;   // restart words give no result; let them drain
   localparam int LONG_HOLD   = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_word;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   rolling_median_spike_detector dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // shadow of the block: registers, history and event state
   // ---------------------------------------------------------------
   int unsigned en_sh, budget_sh, delta_sh, window_sh, pre_sh, post_sh, maxev_sh;
   logic [19:0] ring_sh [DEPTH];
   logic [19:0] sorted_sh [DEPTH];
   int unsigned hist_len;
   logic [31:0] sample_cnt;
   logic [31:0] last_spike;
   bit          ev_open;
   int unsigned ev_count;
   logic [19:0] peak_sh;

   rsp_type     pending_rsp [$];   // results owed by the block, oldest first
   int          mismatches = 0;
   bit          quiet_rx = 1'b0;   // no random receiver idles while set
   bit          hold_rsp = 1'b0;   // one long receiver stall requested
   int          cycles = 0;

   function automatic int unsigned clamp_val(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void clear_capture();
      hist_len   = 0;
      sample_cnt = '0;
      ev_open    = 1'b0;
      ev_count   = 0;
      last_spike = '0;
      peak_sh    = '0;
   endfunction

   function automatic void drop_oldest();
      logic [19:0] old;
      int unsigned i;
      old = ring_sh[0];
      for (int k = 0; k + 1 < hist_len; k++) ring_sh[k] = ring_sh[k+1];
      i = 0;
      while (i + 1 < hist_len && sorted_sh[i] != old) i++;
      for (int k = i; k + 1 < hist_len; k++) sorted_sh[k] = sorted_sh[k+1];
      hist_len--;
   endfunction

   function automatic void add_sample(logic [19:0] v);
      int unsigned pos;
      pos = 0;
      ring_sh[hist_len] = v;
      while (pos < hist_len && sorted_sh[pos] <= v) pos++;
      for (int k = hist_len; k > pos; k--) sorted_sh[k] = sorted_sh[k-1];
      sorted_sh[pos] = v;
      hist_len++;
   endfunction

   // one frame word in, the result word it must produce out
   function automatic rsp_type spike_verdict(logic [19:0] f);
      rsp_type     r;
      logic [31:0] idx;
      longint unsigned lo, hi;
      int unsigned mid, cap;
      r   = '0;
      idx = sample_cnt;
      if (sample_cnt != 32'hFFFF_FFFF) sample_cnt++;
      if (en_sh != 0) begin
         if (hist_len >= window_sh && hist_len > 0) begin
            mid = hist_len / 2;
            if ((hist_len % 2) == 0) begin
               lo = sorted_sh[mid-1];
               hi = sorted_sh[mid];
            end else begin
               lo = sorted_sh[mid];
               hi = lo;
            end
            r.baseline_ready = 1'b1;
            r.median_us = 20'((lo + hi) >> 1);
            // exact test on doubled values, no rounding of the median
            if (f >= budget_sh && 2 * longint'(f) >= lo + hi + 2 * longint'(delta_sh))
               r.is_spike = 1'b1;
         end
         if (ev_open) begin
            if (r.is_spike) begin
               last_spike = idx;
               if (f > peak_sh) begin
                  peak_sh = f;
                  r.peak_updated = 1'b1;
               end
            end else if (32'(idx - last_spike) >= post_sh) begin
               ev_open = 1'b0;
               r.event_ended = 1'b1;
            end
         end else if (r.is_spike && ev_count < maxev_sh) begin
            ev_count++;
            ev_open        = 1'b1;
            last_spike     = idx;
            peak_sh        = f;
            r.event_started = 1'b1;
            r.peak_updated  = 1'b1;
            r.window_start  = idx >= pre_sh ? idx - pre_sh : '0;
         end
         // shrink to the current history limit before the new sample goes in
         cap = window_sh > pre_sh ? window_sh : pre_sh;
         while (hist_len > 0 && (hist_len >= cap || hist_len >= DEPTH)) drop_oldest();
         add_sample(f);
         r.event_active = ev_open;
      end
      r.frame_index  = idx;
      r.event_number = EVENT_W'(ev_count);
      return r;
   endfunction

   // ---------------------------------------------------------------
   // csr access
   // ---------------------------------------------------------------
   task automatic csr_write(logic [2:0] reg_idx, logic [31:0] value);
      int unsigned want;
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {reg_idx, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (reg_idx)
         REG_SPIKE_ENABLE: begin en_sh = value[0]; want = en_sh; end
         REG_FRAME_BUDGET: begin budget_sh = clamp_val(value[19:0], 100, 1000000); want = budget_sh; end
         REG_DELTA_THRESH: begin delta_sh = clamp_val(value[19:0], 10, 1000000); want = delta_sh; end
         REG_WINDOW:       begin window_sh = clamp_val(value[9:0], 30, 600); want = window_sh; end
         REG_PRE:          begin pre_sh = clamp_val(value[8:0], 0, 300); want = pre_sh; end
         REG_POST:         begin post_sh = clamp_val(value[9:0], 0, 600); want = post_sh; end
         default:          begin maxev_sh = clamp_val(value[6:0], 1, 100); want = maxev_sh; end
      endcase
      // read back: the stored value is the clamped one
      @(negedge clock);
      pwrite <= 1'b0; penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("csr %0d readback: expected %0d, got %0d", reg_idx, want, prdata);
      end
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0;
   endtask

   task automatic set_config(int unsigned en, budget, delta, window, pre, post, maxev);
      csr_write(REG_SPIKE_ENABLE, en);
      csr_write(REG_FRAME_BUDGET, budget);
      csr_write(REG_DELTA_THRESH, delta);
      csr_write(REG_WINDOW, window);
      csr_write(REG_PRE, pre);
      csr_write(REG_POST, post);
      csr_write(REG_MAX_EVENTS, maxev);
   endtask

   // ---------------------------------------------------------------
   // request side: one word per call; valid stays up across back-to-back words
   // ---------------------------------------------------------------
   bit send_idle = 1'b0;

   task automatic send_word(req_type w, bit typed, rsp_type typed_rsp);
      int gap;
      rsp_type r;
      gap = send_idle ? $urandom_range(0, 17) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      if (w.func == FUNC_RESTART) begin
         clear_capture();
      end else begin
         r = spike_verdict(w.frame_us);
         pending_rsp.push_back(typed ? typed_rsp : r);
      end
   endtask

   // drop valid, then wait for every owed word plus the restart drain
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------
   initial begin
      rsp_type want;
      int gap;
      @(negedge clock);
      forever begin
         gap = quiet_rx ? 0 : $urandom_range(0, 17);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            gap = LONG_HOLD;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %p", rsp_word);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_word !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch\n  expected %p\n  actual   %p", want, rsp_word);
            end
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   typedef struct {
      logic        func;
      logic [19:0] frame;
      bit          typed;
      rsp_type     want;
   } step_row;

   // phase: en, budget, delta, window, pre, post, maxev, words
   typedef struct {
      int unsigned en, budget, delta, window, pre, post, maxev, words;
   } phase_row;

   task automatic random_phase(int unsigned words);
      int unsigned base, pick;
      req_type w;
      base = $urandom_range(5000, 15000);
      for (int n = 0; n < words; n++) begin
         pick = $urandom_range(0, 99);
         w.func = FUNC_SAMPLE;
         if (pick < 4) begin
            w.func = FUNC_RESTART;
            w.frame_us = 20'($urandom);
         end else if (pick < 10) begin
            w.frame_us = 20'($urandom);                         // full range noise
         end else if (pick < 26) begin
            w.frame_us = 20'(base + $urandom_range(3000, 40000)); // hitch
         end else begin
            w.frame_us = 20'(base + $urandom_range(0, 2000) - 1000);
         end
         send_word(w, 1'b0, '0);
      end
   endtask

   initial begin
      step_row  steps [$];
      phase_row phases [$];
      rsp_type  t;
      req_type  w;

      en_sh = 1; budget_sh = 16667; delta_sh = 5000; window_sh = 120;
      pre_sh = 30; post_sh = 30; maxev_sh = 10;
      clear_capture();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // below-range writes clamp to the minimum
      set_config(1, 0, 0, 0, 0, 0, 0);

      // directed: first words after restart have known results
      t = '0;
      steps.push_back('{FUNC_RESTART, 20'hFFFFF, 1'b0, t});
      steps.push_back('{FUNC_SAMPLE, 20'd0, 1'b1, t});
      t.frame_index = 1;
      steps.push_back('{FUNC_SAMPLE, 20'hFFFFF, 1'b1, t});
      for (int k = 0; k < 28; k++)
         steps.push_back('{FUNC_SAMPLE, 20'(10000 + 37 * k), 1'b0, t});
      steps.push_back('{FUNC_SAMPLE, 20'd10509, 1'b0, t});  // just below median+delta
      steps.push_back('{FUNC_SAMPLE, 20'hFFFFF, 1'b0, t});  // opens the only event
      steps.push_back('{FUNC_SAMPLE, 20'd9000, 1'b0, t});   // post 0: closes at once
      steps.push_back('{FUNC_SAMPLE, 20'hFFFFF, 1'b0, t});  // event limit reached
      foreach (steps[i]) begin
         w.func = steps[i].func;
         w.frame_us = steps[i].frame;
         send_word(w, steps[i].typed, steps[i].want);
      end
      drain();

      phases.push_back('{1, 100, 10, 30, 0, 0, 1, 90});
      phases.push_back('{1, 16667, 5000, 30, 511, 30, 10, 110});   // pre clamps to 300
      phases.push_back('{1, 16667, 5000, 30, 0, 5, 127, 90});      // history shrinks
      phases.push_back('{0, 16667, 5000, 30, 0, 5, 127, 60});      // detection off
      phases.push_back('{1, 20'hFFFFF, 20'hFFFFF, 30, 50, 1023, 3, 80});
      phases.push_back('{1, 20000, 3000, 45, 10, 20, 50, 90});
      phases.push_back('{1, 12000, 2000, 1023, 0, 10, 100, 80});   // window clamps to 600
      phases.push_back('{1, 12000, 2000, 40, 20, 10, 100, 90});

      foreach (phases[p]) begin
         set_config(phases[p].en, phases[p].budget, phases[p].delta, phases[p].window,
                    phases[p].pre, phases[p].post, phases[p].maxev);
         send_idle = ($urandom_range(0, 2) != 0);
         quiet_rx  = ($urandom_range(0, 3) == 0);
         // the receiver stalls long while words keep coming and the block backs up
         if (p == 1) begin
            send_idle = 1'b0;
            hold_rsp  = 1'b1;
         end
         random_phase(phases[p].words);
         drain();
      end

      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ rolling_median_spike_detector.f @@
sv/rmsd_pkg.sv
sv/rmsd_cell.sv
sv/rmsd_chain.sv
sv/rolling_median_spike_detector.sv
sv/rmsd_checker.sv
bench/tb_top.sv
